[hdl/sgr_pkg.sv]
`default_nettype none

package sgr_pkg;

    localparam int COORD_BITS = 16;
    localparam int WIDE_BITS  = COORD_BITS + 2;
    localparam int HALF_BITS  = 8;
    localparam int S_TDATA_W  = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = 10;
    localparam int M_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;
    localparam int APB_AW     = 3;

    localparam logic [HALF_BITS-1:0] HALF_RESET = HALF_BITS'(16);
    localparam logic [0:0]           REG_BOX_HALF_SIZE = 1'b0;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [WIDE_BITS-1:0]  t_wide;
    typedef logic [HALF_BITS-1:0]         t_half;
    typedef logic [1:0]                   t_len;

    typedef enum logic [1:0] {
        OP_PRESS   = 2'd0,
        OP_MOVE    = 2'd1,
        OP_RELEASE = 2'd2,
        OP_UNUSED  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        DIR_NONE  = 3'd0,
        DIR_LEFT  = 3'd1,
        DIR_RIGHT = 3'd2,
        DIR_UP    = 3'd3,
        DIR_DOWN  = 3'd4
    } t_dir;

    typedef enum logic [3:0] {
        CMD_UNKNOWN = 4'd0,
        CMD_RL      = 4'd1,
        CMD_LR      = 4'd2,
        CMD_L       = 4'd3,
        CMD_R       = 4'd4,
        CMD_U       = 4'd5,
        CMD_UD      = 4'd6,
        CMD_DU      = 4'd7,
        CMD_DR      = 4'd8,
        CMD_DL      = 4'd9,
        CMD_D       = 4'd10
    } t_cmd;

    typedef struct packed {
        t_dir first_dir;
        t_dir second_dir;
        t_len length;
    } t_stroke;

endpackage

`default_nettype wire

[hdl/sgr_classify.sv]
`default_nettype none

module sgr_classify (
    input  sgr_pkg::t_coord i_x,
    input  sgr_pkg::t_coord i_y,
    input  sgr_pkg::t_coord i_anchor_x,
    input  sgr_pkg::t_coord i_anchor_y,
    input  sgr_pkg::t_half  i_half,
    output sgr_pkg::t_dir   o_dir
);
    import sgr_pkg::*;

    t_wide w_x;
    t_wide w_y;
    t_wide w_ax;
    t_wide w_ay;
    t_wide w_h;

    assign w_x  = {{(WIDE_BITS - COORD_BITS){i_x[COORD_BITS-1]}}, i_x};
    assign w_y  = {{(WIDE_BITS - COORD_BITS){i_y[COORD_BITS-1]}}, i_y};
    assign w_ax = {{(WIDE_BITS - COORD_BITS){i_anchor_x[COORD_BITS-1]}}, i_anchor_x};
    assign w_ay = {{(WIDE_BITS - COORD_BITS){i_anchor_y[COORD_BITS-1]}}, i_anchor_y};
    assign w_h  = {{(WIDE_BITS - HALF_BITS){1'b0}}, i_half};

    always_comb begin
        if (w_x <= w_ax - w_h) begin
            o_dir = DIR_LEFT;
        end else if (w_x >= w_ax + w_h) begin
            o_dir = DIR_RIGHT;
        end else if (w_y <= w_ay - w_h) begin
            o_dir = DIR_UP;
        end else if (w_y >= w_ay + w_h) begin
            o_dir = DIR_DOWN;
        end else begin
            o_dir = DIR_NONE;
        end
    end

endmodule

`default_nettype wire

[hdl/sgr_match.sv]
`default_nettype none

module sgr_match (
    input  sgr_pkg::t_stroke i_stroke,
    output sgr_pkg::t_cmd    o_cmd
);
    import sgr_pkg::*;

    always_comb begin
        o_cmd = CMD_UNKNOWN;
        case (i_stroke.length)
            2'd1: begin
                case (i_stroke.first_dir)
                    DIR_LEFT:  o_cmd = CMD_L;
                    DIR_RIGHT: o_cmd = CMD_R;
                    DIR_UP:    o_cmd = CMD_U;
                    DIR_DOWN:  o_cmd = CMD_D;
                    default:   o_cmd = CMD_UNKNOWN;
                endcase
            end
            2'd2: begin
                case (i_stroke.first_dir)
                    DIR_RIGHT: begin
                        if (i_stroke.second_dir == DIR_LEFT) o_cmd = CMD_RL;
                    end
                    DIR_LEFT: begin
                        if (i_stroke.second_dir == DIR_RIGHT) o_cmd = CMD_LR;
                    end
                    DIR_UP: begin
                        if (i_stroke.second_dir == DIR_DOWN) o_cmd = CMD_UD;
                    end
                    DIR_DOWN: begin
                        case (i_stroke.second_dir)
                            DIR_UP:    o_cmd = CMD_DU;
                            DIR_RIGHT: o_cmd = CMD_DR;
                            DIR_LEFT:  o_cmd = CMD_DL;
                            default:   o_cmd = CMD_UNKNOWN;
                        endcase
                    end
                    default: o_cmd = CMD_UNKNOWN;
                endcase
            end
            default: o_cmd = CMD_UNKNOWN;
        endcase
    end

endmodule

`default_nettype wire

[hdl/stroke_gesture_recognizer.sv]
// An input transfer fills the input register, then its result fills the result register.
// Throughput: one event per cycle unless stalled; stroke state updates in the single stage.
// The result register frees its slot in the same cycle its transfer completes.
// Synchronous active-low reset clears the stroke, anchor and handshake state
// and sets the dead-zone half size to 16.
`default_nettype none

module stroke_gesture_recognizer (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // Fields from bit 0: x_pos, y_pos.
    input  wire  [sgr_pkg::S_TDATA_W-1:0]    i_s_axis_tdata,
    // Fields from bit 0: opcode.
    input  wire  [1:0]                       i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  wire                              i_m_axis_tready,
    // Fields from bit 0: direction_added, stroke_length, command_valid, command, zero pad.
    output logic [sgr_pkg::M_TDATA_W-1:0]    o_m_axis_tdata,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire  [sgr_pkg::APB_AW-1:0]       paddr,
    input  wire  [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import sgr_pkg::*;

    t_half   r_half;

    logic    r_in_valid;
    t_op     r_in_op;
    t_coord  r_in_x;
    t_coord  r_in_y;

    logic    r_open;
    t_coord  r_anchor_x;
    t_coord  r_anchor_y;
    t_stroke r_stroke;
    t_dir    r_last_dir;

    logic    n_open;
    t_coord  n_anchor_x;
    t_coord  n_anchor_y;
    t_stroke n_stroke;
    t_dir    n_last_dir;

    logic    r_out_valid;
    t_dir    r_out_dir;
    t_len    r_out_len;
    logic    r_out_cmd_valid;
    t_cmd    r_out_cmd;

    t_dir    n_out_dir;
    t_len    n_out_len;
    logic    n_out_cmd_valid;
    t_cmd    n_out_cmd;

    logic    w_adv;
    t_dir    w_dir;
    t_cmd    w_cmd;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_BOX_HALF_SIZE) ? {{(32 - HALF_BITS){1'b0}}, r_half} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= HALF_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_BOX_HALF_SIZE)) begin
            r_half <= pwdata[HALF_BITS-1:0];
        end
    end

    assign w_adv           = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_op <= t_op'(i_s_axis_tuser);
            r_in_x  <= i_s_axis_tdata[COORD_BITS-1:0];
            r_in_y  <= i_s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
        end
    end

    sgr_classify u_classify (
        .i_x        (r_in_x),
        .i_y        (r_in_y),
        .i_anchor_x (r_anchor_x),
        .i_anchor_y (r_anchor_y),
        .i_half     (r_half),
        .o_dir      (w_dir)
    );

    sgr_match u_match (
        .i_stroke (r_stroke),
        .o_cmd    (w_cmd)
    );

    always_comb begin
        n_open          = r_open;
        n_anchor_x      = r_anchor_x;
        n_anchor_y      = r_anchor_y;
        n_stroke        = r_stroke;
        n_last_dir      = r_last_dir;
        n_out_dir       = DIR_NONE;
        n_out_len       = r_stroke.length;
        n_out_cmd_valid = 1'b0;
        n_out_cmd       = CMD_UNKNOWN;
        case (r_in_op)
            OP_PRESS: begin
                n_open     = 1'b1;
                n_anchor_x = r_in_x;
                n_anchor_y = r_in_y;
                n_stroke   = '{first_dir: DIR_NONE, second_dir: DIR_NONE, length: 2'd0};
                n_last_dir = DIR_NONE;
                n_out_len  = 2'd0;
            end
            OP_MOVE: begin
                if (r_open && (w_dir != DIR_NONE)) begin
                    n_anchor_x = r_in_x;
                    n_anchor_y = r_in_y;
                    if (w_dir != r_last_dir) begin
                        if (r_stroke.length == 2'd0) begin
                            n_stroke.first_dir = w_dir;
                        end else if (r_stroke.length == 2'd1) begin
                            n_stroke.second_dir = w_dir;
                        end
                        if (r_stroke.length != 2'd3) begin
                            n_stroke.length = r_stroke.length + 2'd1;
                        end
                        n_last_dir = w_dir;
                        n_out_dir  = w_dir;
                    end
                end
                n_out_len = n_stroke.length;
            end
            OP_RELEASE: begin
                if (r_open && (r_stroke.length != 2'd0)) begin
                    n_out_cmd_valid = 1'b1;
                    n_out_cmd       = w_cmd;
                end
                n_open     = 1'b0;
                n_stroke   = '{first_dir: DIR_NONE, second_dir: DIR_NONE, length: 2'd0};
                n_last_dir = DIR_NONE;
            end
            default: begin
                n_out_len = r_stroke.length;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open     <= 1'b0;
            r_anchor_x <= '0;
            r_anchor_y <= '0;
            r_stroke   <= '{first_dir: DIR_NONE, second_dir: DIR_NONE, length: 2'd0};
            r_last_dir <= DIR_NONE;
        end else if (w_adv) begin
            r_open     <= n_open;
            r_anchor_x <= n_anchor_x;
            r_anchor_y <= n_anchor_y;
            r_stroke   <= n_stroke;
            r_last_dir <= n_last_dir;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_dir       <= n_out_dir;
            r_out_len       <= n_out_len;
            r_out_cmd_valid <= n_out_cmd_valid;
            r_out_cmd       <= n_out_cmd;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(M_TDATA_W - OUT_BITS){1'b0}},
                              r_out_cmd, r_out_cmd_valid, r_out_len, r_out_dir};

    // A closed stroke never holds directions.
    a_closed_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_open |-> (r_stroke.length == 2'd0 && r_last_dir == DIR_NONE))
        else $error("closed stroke holds directions");

    // The last direction is set exactly when the stroke is non-empty.
    a_last_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stroke.length == 2'd0) == (r_last_dir == DIR_NONE))
        else $error("last direction disagrees with stroke length");

    // A command is reported only for a non-empty stroke, and is zero otherwise.
    a_cmd_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_cmd_valid && r_out_len != 2'd0)
                         || (!r_out_cmd_valid && r_out_cmd == CMD_UNKNOWN)))
        else $error("command result inconsistent with stroke length");

    // An appended direction always leaves a non-empty stroke and no command.
    a_dir_added: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_dir != DIR_NONE) |-> (r_out_len != 2'd0 && !r_out_cmd_valid))
        else $error("direction appended with empty stroke");

    // Every advance leaves a result waiting in the next cycle.
    a_adv_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_out_valid)
        else $error("advanced item produced no result");

endmodule

`default_nettype wire

[dv/tb_top.sv]
`default_nettype none

module tb_top;

    import sgr_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 80;
    localparam int NUM_PHASES  = 8;
    localparam int PHASE_ITEMS = 250;

    typedef struct packed {
        t_dir dir;
        t_len len;
        logic valid;
        t_cmd cmd;
    } t_gesture_result;

    typedef struct packed {
        t_op             op;
        t_coord          x;
        t_coord          y;
        logic            typed;
        t_gesture_result res;
    } t_stim_row;

    localparam t_gesture_result NO_RESULT = '{DIR_NONE, 2'd0, 1'b0, CMD_UNKNOWN};

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_axis_tvalid;
    logic                 o_s_axis_tready;
    logic [S_TDATA_W-1:0] i_s_axis_tdata;
    logic [1:0]           i_s_axis_tuser;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready;
    logic [M_TDATA_W-1:0] o_m_axis_tdata;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [APB_AW-1:0]    paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    stroke_gesture_recognizer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // Shadow copy of the recognizer state.
    t_half  box_half   = HALF_RESET;
    logic   gst_open   = 1'b0;
    t_coord gst_anchor_x = '0;
    t_coord gst_anchor_y = '0;
    t_dir   gst_first  = DIR_NONE;
    t_dir   gst_second = DIR_NONE;
    t_dir   gst_last   = DIR_NONE;
    t_len   gst_len    = 2'd0;

    t_gesture_result pending_results[$];
    int  error_count   = 0;
    int  cycle_count   = 0;
    bit  no_idle       = 1'b0;
    bit  long_hold_req = 1'b0;

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic int idle_len();
        if ($urandom_range(0, 9) < 8) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 30);
    endfunction

    function automatic t_coord rand_coord();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            default: return t_coord'($urandom);
        endcase
    endfunction

    function automatic t_gesture_result predict_gesture(t_op op, t_coord x, t_coord y);
        t_gesture_result r;
        t_dir d;
        int   xv, yv, ax, ay, hv;
        r  = NO_RESULT;
        xv = x;
        yv = y;
        ax = gst_anchor_x;
        ay = gst_anchor_y;
        hv = box_half;
        case (op)
            OP_PRESS: begin
                gst_first    = DIR_NONE;
                gst_second   = DIR_NONE;
                gst_last     = DIR_NONE;
                gst_len      = 2'd0;
                gst_anchor_x = x;
                gst_anchor_y = y;
                gst_open     = 1'b1;
            end
            OP_MOVE: begin
                if (gst_open) begin
                    if (xv <= ax - hv) d = DIR_LEFT;
                    else if (xv >= ax + hv) d = DIR_RIGHT;
                    else if (yv <= ay - hv) d = DIR_UP;
                    else if (yv >= ay + hv) d = DIR_DOWN;
                    else d = DIR_NONE;
                    if (d != DIR_NONE) begin
                        gst_anchor_x = x;
                        gst_anchor_y = y;
                        if (d != gst_last) begin
                            if (gst_len == 2'd0) gst_first = d;
                            else if (gst_len == 2'd1) gst_second = d;
                            if (gst_len < 2'd3) gst_len++;
                            gst_last = d;
                            r.dir = d;
                        end
                    end
                end
                r.len = gst_len;
            end
            OP_RELEASE: begin
                r.len = gst_len;
                if (gst_open && gst_len != 2'd0) begin
                    r.valid = 1'b1;
                    if (gst_len == 2'd1) begin
                        case (gst_first)
                            DIR_LEFT:  r.cmd = CMD_L;
                            DIR_RIGHT: r.cmd = CMD_R;
                            DIR_UP:    r.cmd = CMD_U;
                            DIR_DOWN:  r.cmd = CMD_D;
                            default:   r.cmd = CMD_UNKNOWN;
                        endcase
                    end else if (gst_len == 2'd2) begin
                        if (gst_first == DIR_RIGHT && gst_second == DIR_LEFT) r.cmd = CMD_RL;
                        else if (gst_first == DIR_LEFT && gst_second == DIR_RIGHT) r.cmd = CMD_LR;
                        else if (gst_first == DIR_UP && gst_second == DIR_DOWN) r.cmd = CMD_UD;
                        else if (gst_first == DIR_DOWN && gst_second == DIR_UP) r.cmd = CMD_DU;
                        else if (gst_first == DIR_DOWN && gst_second == DIR_RIGHT) r.cmd = CMD_DR;
                        else if (gst_first == DIR_DOWN && gst_second == DIR_LEFT) r.cmd = CMD_DL;
                    end
                end
                gst_open   = 1'b0;
                gst_first  = DIR_NONE;
                gst_second = DIR_NONE;
                gst_last   = DIR_NONE;
                gst_len    = 2'd0;
            end
            default: begin
                r.len = gst_len;
            end
        endcase
        return r;
    endfunction

    // Starts at a rising edge or time zero and returns at the edge of the transfer.
    task automatic send_event(input t_op op, input t_coord x, input t_coord y,
                              input logic typed, input t_gesture_result typed_res);
        t_gesture_result r;
        @(negedge i_clk);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid = 1'b0;
            repeat (idle_len() - 1) @(negedge i_clk);
            @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = S_TDATA_W'({y, x});
        i_s_axis_tuser  = op;
        do begin
            @(posedge i_clk);
        end while (!o_s_axis_tready);
        r = predict_gesture(op, x, y);
        pending_results.push_back(typed ? typed_res : r);
    endtask

    task automatic wait_drain();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_box_half(input t_half value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = APB_AW'(4 * REG_BOX_HALF_SIZE);
        pwdata  = 32'(value);
        @(negedge i_clk);
        penable = 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        box_half = value;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic random_move(input t_op op);
        int ax, ay, hv, mag, side, k;
        t_coord tx, ty;
        ax   = gst_anchor_x;
        ay   = gst_anchor_y;
        hv   = box_half;
        k    = $urandom_range(0, 9);
        if (k < 3) begin
            mag = (hv > 0) ? int'($urandom_range(0, hv - 1)) : 0;
        end else begin
            mag = hv + int'($urandom_range(0, (k == 9) ? 3000 : 8));
        end
        side = int'($urandom_range(0, 2 * hv)) - hv;
        case ($urandom_range(0, 3))
            0: begin tx = t_coord'(ax - mag); ty = t_coord'(ay + side); end
            1: begin tx = t_coord'(ax + mag); ty = t_coord'(ay + side); end
            2: begin tx = t_coord'(ax + side); ty = t_coord'(ay - mag); end
            default: begin tx = t_coord'(ax + side); ty = t_coord'(ay + mag); end
        endcase
        send_event(op, tx, ty, 1'b0, NO_RESULT);
    endtask

    task automatic random_gesture(output int sent);
        int moves;
        moves = $urandom_range(0, 6);
        send_event(OP_PRESS, rand_coord(), rand_coord(), 1'b0, NO_RESULT);
        for (int m = 0; m < moves; m++) begin
            random_move(OP_MOVE);
        end
        sent = moves + 1;
        if ($urandom_range(0, 9) != 0) begin
            send_event(OP_RELEASE, rand_coord(), rand_coord(), 1'b0, NO_RESULT);
            sent++;
        end
    endtask

    function automatic void check_field(string name, int expected, int actual);
        if (expected != actual) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name,
                     expected, actual);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_gesture_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result transfer, expected none, actual %h",
                         $time, o_m_axis_tdata);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("direction_added", want.dir, o_m_axis_tdata[2:0]);
                check_field("stroke_length", want.len, o_m_axis_tdata[4:3]);
                check_field("command_valid", want.valid, o_m_axis_tdata[5]);
                check_field("command", want.cmd, o_m_axis_tdata[9:6]);
            end
        end
    end

    initial begin
        int rx_wait;
        rx_wait = 0;
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                rx_wait = LONG_HOLD;
            end else if (rx_wait == 0 && !no_idle && $urandom_range(0, 3) == 0) begin
                rx_wait = idle_len();
            end
            if (rx_wait > 0) begin
                i_m_axis_tready = 1'b0;
                rx_wait--;
            end else begin
                i_m_axis_tready = 1'b1;
            end
        end
    end

    t_stim_row directed_rows[24] = '{
        '{OP_MOVE,    16'sd0,    16'sd0,     1'b1, NO_RESULT},
        '{OP_RELEASE, 16'sd0,    16'sd0,     1'b1, NO_RESULT},
        '{OP_UNUSED,  16'sd1234, -16'sd1234, 1'b1, NO_RESULT},
        '{OP_PRESS,   16'sd0,    16'sd0,     1'b1, NO_RESULT},
        '{OP_MOVE,    16'sd5,    -16'sd5,    1'b1, NO_RESULT},
        '{OP_MOVE,    -16'sd16,  16'sd0,     1'b1, '{DIR_LEFT, 2'd1, 1'b0, CMD_UNKNOWN}},
        '{OP_MOVE,    -16'sd32,  16'sd0,     1'b1, '{DIR_NONE, 2'd1, 1'b0, CMD_UNKNOWN}},
        '{OP_RELEASE, 16'sd0,    16'sd0,     1'b1, '{DIR_NONE, 2'd1, 1'b1, CMD_L}},
        '{OP_PRESS,   16'sh7fff, 16'sh7fff,  1'b1, NO_RESULT},
        '{OP_MOVE,    16'sh7fff, 16'sh8000,  1'b0, NO_RESULT},
        '{OP_MOVE,    16'sh7fff, 16'sh7fff,  1'b0, NO_RESULT},
        '{OP_RELEASE, 16'sh7fff, 16'sh7fff,  1'b0, NO_RESULT},
        '{OP_PRESS,   16'sh8000, 16'sh8000,  1'b1, NO_RESULT},
        '{OP_MOVE,    16'sh8000, 16'sh8000,  1'b0, NO_RESULT},
        '{OP_MOVE,    16'sh7fff, 16'sh8000,  1'b0, NO_RESULT},
        '{OP_MOVE,    16'sh8000, 16'sh8000,  1'b0, NO_RESULT},
        '{OP_MOVE,    16'sd0,    16'sh7fff,  1'b0, NO_RESULT},
        '{OP_RELEASE, 16'sd0,    16'sd0,     1'b1, '{DIR_NONE, 2'd3, 1'b1, CMD_UNKNOWN}},
        '{OP_PRESS,   16'sd100,  16'sd100,   1'b1, NO_RESULT},
        '{OP_MOVE,    16'sd100,  16'sd116,   1'b0, NO_RESULT},
        '{OP_MOVE,    16'sd116,  16'sd116,   1'b0, NO_RESULT},
        '{OP_PRESS,   16'sd0,    16'sd0,     1'b1, NO_RESULT},
        '{OP_RELEASE, 16'sd0,    16'sd0,     1'b1, NO_RESULT},
        '{OP_UNUSED,  -16'sd1,   -16'sd1,    1'b1, NO_RESULT}
    };

    t_half phase_half[NUM_PHASES];

    initial begin
        int sent, count;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            send_event(directed_rows[i].op, directed_rows[i].x, directed_rows[i].y,
                       directed_rows[i].typed, directed_rows[i].res);
        end
        wait_drain();

        phase_half = '{8'd1, 8'd255, 8'd0, 8'd16, t_half'($urandom_range(1, 255)),
                       8'd2, t_half'($urandom_range(1, 255)), 8'd40};
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_box_half(phase_half[p]);
            @(posedge i_clk);
            no_idle = (p == 5);
            if (p == 3) long_hold_req = 1'b1;
            count = 0;
            while (count < PHASE_ITEMS) begin
                if ($urandom_range(0, 4) != 0) begin
                    random_gesture(sent);
                    count += sent;
                end else if ($urandom_range(0, 1) == 0) begin
                    random_move(t_op'($urandom_range(0, 3)));
                    count++;
                end else begin
                    send_event(t_op'($urandom_range(0, 3)), rand_coord(), rand_coord(),
                               1'b0, NO_RESULT);
                    count++;
                end
                if (p == 6 && count >= PHASE_ITEMS / 2 && count < PHASE_ITEMS / 2 + 8) begin
                    wait_drain();
                    count += 8;
                end
            end
            wait_drain();
        end
        no_idle = 1'b0;

        if (error_count == 0 && pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
